### hdl/psrl_pkg.sv
// Types and constants for the per-source connect rate limiter.
// No dependencies; imported by per_source_connect_rate_limiter.
`timescale 1ns / 1ps
`default_nettype none

package psrl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [1:0] CFG_EXPIRY_TICKS = 2'd2;

    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd5;
    localparam logic [31:0] WINDOW_TICKS_RST = 32'd10000;
    localparam logic [31:0] EXPIRY_TICKS_RST = 32'd60000;

    localparam logic [7:0]  COUNT_MAX  = 8'd255;
    localparam logic [6:0]  PURGED_MAX = 7'd127;

    // Item operation codes
    localparam logic OP_CONNECT = 1'b0;
    localparam logic OP_PURGE   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] source_addr;
        logic [31:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic       limited;
        logic [7:0] attempt_count;
        logic       table_full;
        logic [6:0] purged_count;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] last_time;
        logic [7:0]  count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hdl/per_source_connect_rate_limiter.sv
// Per-source connection rate limiter: top level with the entry table memory.
// Depends on psrl_pkg (item, entry and state types, register indexes).
`timescale 1ns / 1ps
`default_nettype none

// The block tracks up to TABLE_ENTRIES source addresses in one synchronous
// memory (valid bit, address, last attempt time, saturating count per entry).
// After reset it runs a clearing pass that writes every entry invalid; no
// item is accepted during that pass, but configuration writes are taken at
// any time. Each item then sweeps the whole table through the memory's
// single read port, one entry per cycle: a connect item searches for its
// address and the lowest free slot, a purge item invalidates every entry idle
// longer than expiry_ticks as the sweep passes it. After the sweep a connect
// item goes through ST_UPDATE and ST_DONE to the output register, a purge
// item straight through ST_DONE.
// One item is in work at a time; the output register holds a finished result
// while the next item is accepted. Time gaps are computed modulo 2^32; a gap
// equal to the window or expiry does not count as longer. A new source that
// finds the table full is passed unlimited with table_full set and not stored.
module per_source_connect_rate_limiter
    import psrl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,

    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,

    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(TABLE_ENTRIES);

    // Configuration registers
    logic [7:0]  max_attempts_reg;
    logic [31:0] window_ticks_reg;
    logic [31:0] expiry_ticks_reg;

    // Control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             hit_found_reg, hit_found_next;
    logic             free_found_reg, free_found_next;
    logic [6:0]       purged_reg, purged_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    in_item_t         item_reg, item_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [7:0]       hit_count_reg, hit_count_next;
    logic             hit_over_reg, hit_over_next;
    out_item_t        res_reg, res_next;
    out_item_t        out_reg, out_next;

    // Entry table memory
    entry_t           mem [TABLE_ENTRIES];
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;

    // Update datapath
    logic [31:0] gap;
    logic        gap_over;
    logic [7:0]  new_count;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
            rd_idx_reg  <= rd_idx;
        end
    end

    assign rd_idx = cnt_reg[IDX_W-1:0];

    // Idle gap of the entry under the sweep, against window or expiry
    assign gap      = item_reg.now_ticks - rd_data_reg.last_time;
    assign gap_over = (item_reg.op == OP_PURGE) ? (gap > expiry_ticks_reg)
                                                : (gap > window_ticks_reg);

    // Restart on a long gap, else advance and saturate
    assign new_count = hit_over_reg ? 8'd1
                     : ((hit_count_reg == COUNT_MAX) ? COUNT_MAX : hit_count_reg + 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            window_ticks_reg <= WINDOW_TICKS_RST;
            expiry_ticks_reg <= EXPIRY_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[7:0];
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data;
                CFG_EXPIRY_TICKS: expiry_ticks_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            purged_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_pend_reg    <= rd_pend_next;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            purged_reg     <= purged_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        hit_count_reg <= hit_count_next;
        hit_over_reg  <= hit_over_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = rd_pend_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        purged_next     = purged_reg;
        item_next       = item_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_count_next  = hit_count_reg;
        hit_over_next   = hit_over_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = rd_idx;
        wr_data         = '0;

        // Drop the output item once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Write every entry invalid, one a cycle
                if (cnt_reg != SWEEP_END)
                begin
                    wr_en    = 1'b1;
                    wr_idx   = rd_idx;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next       = in_data;
                    cnt_next        = '0;
                    rd_pend_next    = 1'b0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    purged_next     = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (cnt_reg != SWEEP_END)
                begin
                    rd_en        = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end

                // Examine the entry read last cycle
                if (rd_pend_reg)
                begin
                    if (item_reg.op == OP_PURGE)
                    begin
                        if (rd_data_reg.valid && gap_over)
                        begin
                            wr_en         = 1'b1;
                            wr_idx        = rd_idx_reg;
                            wr_data       = rd_data_reg;
                            wr_data.valid = 1'b0;
                            if (purged_reg != PURGED_MAX)
                            begin
                                purged_next = purged_reg + 7'd1;
                            end
                        end
                    end
                    else if (rd_data_reg.valid)
                    begin
                        if (!hit_found_reg && rd_data_reg.addr == item_reg.source_addr)
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = rd_idx_reg;
                            hit_count_next = rd_data_reg.count;
                            hit_over_next  = gap_over;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end

                if (cnt_reg == SWEEP_END && !rd_pend_reg)
                begin
                    if (item_reg.op == OP_PURGE)
                    begin
                        res_next              = '0;
                        res_next.purged_count = purged_reg;
                        state_next            = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                res_next               = '0;
                res_next.attempt_count = 8'd1;
                wr_data.valid          = 1'b1;
                wr_data.addr           = item_reg.source_addr;
                wr_data.last_time      = item_reg.now_ticks;
                wr_data.count          = 8'd1;
                if (hit_found_reg)
                begin
                    wr_en                  = 1'b1;
                    wr_idx                 = hit_idx_reg;
                    wr_data.count          = new_count;
                    res_next.attempt_count = new_count;
                    res_next.limited       = !hit_over_reg && (new_count > max_attempts_reg);
                end
                else if (free_found_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx_reg;
                end
                else
                begin
                    res_next.table_full = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for per_source_connect_rate_limiter.
// Depends on psrl_pkg and the block; a queue-fed driver, a verdict predictor
// and a monitor compare every result item with the predicted verdict.
`timescale 1ns / 1ps

module tb_top;
    import psrl_pkg::*;

    localparam int          TABLE_SLOTS = 64;
    // Index 3 is not a register; writes there must leave the block untouched
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    // Directed source addresses: both extremes plus a mixed pattern
    localparam logic [31:0] ADDR_LOW    = 32'h0000_0000;
    localparam logic [31:0] ADDR_HIGH   = 32'hFFFF_FFFF;
    localparam logic [31:0] ADDR_MIXED  = 32'hA5A5_5A5A;
    // Cycles to keep watching the output once nothing is outstanding
    localparam int          DRAIN_CYCLES = 80;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    in_item_t    in_data    = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    out_item_t   out_data;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;

    // Predictor copy of the block's registers and source table
    logic [7:0]  lim_max    = MAX_ATTEMPTS_RST;
    logic [31:0] lim_window = WINDOW_TICKS_RST;
    logic [31:0] lim_expiry = EXPIRY_TICKS_RST;
    logic        tbl_valid [TABLE_SLOTS];
    logic [31:0] tbl_addr  [TABLE_SLOTS];
    logic [31:0] tbl_last  [TABLE_SLOTS];
    logic [7:0]  tbl_count [TABLE_SLOTS];

    in_item_t    items_to_send[$];
    out_item_t   pending_verdicts[$];
    int          n_queued     = 0;
    int          n_accepted   = 0;
    int          mismatches   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        item_taken   = 1'b0;
    logic [31:0] sim_ticks;

    per_source_connect_rate_limiter #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Work out the verdict for one accepted item and advance the table copy.
    // A purge drops entries idle strictly longer than the expiry; a connect
    // hits the first matching valid entry, else takes the lowest free slot,
    // else passes unlimited with table_full set.
    function automatic out_item_t judge_item(in_item_t it);
        out_item_t   verdict;
        int          hit;
        int          free_slot;
        logic [31:0] gap;
        verdict   = '0;
        hit       = -1;
        free_slot = -1;
        if (it.op == OP_PURGE)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                gap = it.now_ticks - tbl_last[i];
                if (tbl_valid[i] && gap > lim_expiry)
                begin
                    tbl_valid[i] = 1'b0;
                    if (verdict.purged_count != PURGED_MAX)
                        verdict.purged_count = verdict.purged_count + 7'd1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (tbl_valid[i])
                begin
                    if (hit < 0 && tbl_addr[i] == it.source_addr)
                        hit = i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (hit >= 0)
            begin
                gap = it.now_ticks - tbl_last[hit];
                if (gap > lim_window)
                begin
                    tbl_count[hit] = 8'd1;
                end
                else
                begin
                    if (tbl_count[hit] != COUNT_MAX)
                        tbl_count[hit] = tbl_count[hit] + 8'd1;
                    verdict.limited = (tbl_count[hit] > lim_max);
                end
                tbl_last[hit]         = it.now_ticks;
                verdict.attempt_count = tbl_count[hit];
            end
            else if (free_slot >= 0)
            begin
                tbl_valid[free_slot]  = 1'b1;
                tbl_addr[free_slot]   = it.source_addr;
                tbl_last[free_slot]   = it.now_ticks;
                tbl_count[free_slot]  = 8'd1;
                verdict.attempt_count = 8'd1;
            end
            else
            begin
                verdict.attempt_count = 8'd1;
                verdict.table_full    = 1'b1;
            end
        end
        return verdict;
    endfunction

    // Driver: present the next item at the falling edge once the previous one
    // was taken. Hold valid and payload while the block stalls.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || item_taken)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= items_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, independent of out_valid
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: check each result item against the oldest verdict, then
    // record the item accepted at this edge and predict its verdict.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result item with no verdict pending");
                    mismatches++;
                end
                else
                begin
                    out_item_t want;
                    want = pending_verdicts.pop_front();
                    if (out_data.limited !== want.limited)
                    begin
                        $error("limited: expected %0d, got %0d",
                               want.limited, out_data.limited);
                        mismatches++;
                    end
                    if (out_data.attempt_count !== want.attempt_count)
                    begin
                        $error("attempt_count: expected %0d, got %0d",
                               want.attempt_count, out_data.attempt_count);
                        mismatches++;
                    end
                    if (out_data.table_full !== want.table_full)
                    begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, out_data.table_full);
                        mismatches++;
                    end
                    if (out_data.purged_count !== want.purged_count)
                    begin
                        $error("purged_count: expected %0d, got %0d",
                               want.purged_count, out_data.purged_count);
                        mismatches++;
                    end
                end
            end
            item_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                pending_verdicts.push_back(judge_item(in_data));
                n_accepted++;
            end
        end
    end

    task automatic queue_item(input logic op, input logic [31:0] addr,
                              input logic [31:0] now);
        in_item_t it;
        it.op          = op;
        it.source_addr = addr;
        it.now_ticks   = now;
        items_to_send.push_back(it);
        n_queued++;
    endtask

    // Write one register at the falling edge and mirror it in the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MAX_ATTEMPTS: lim_max    = value[7:0];
            CFG_WINDOW_TICKS: lim_window = value;
            CFG_EXPIRY_TICKS: lim_expiry = value;
            default: ;
        endcase
    endtask

    // Block until every item is taken and every verdict has been checked
    task automatic wait_idle();
        do
            @(negedge clk);
        while (n_accepted != n_queued || pending_verdicts.size() != 0);
    endtask

    // One random phase: reprogram the limits, then stream attempts drawn
    // mostly from a small address pool (one hot source) so entries get hit
    // again and again, with a few strangers and purges mixed in.
    task automatic run_phase(input logic [7:0] max_att, input logic [31:0] window,
                             input logic [31:0] expiry, input int pool_size,
                             input int hot_pct, input int step_max, input int jump_pct,
                             input int purge_pct, input int snd_idle, input int rcv_idle,
                             input int n_items);
        logic [31:0] pool[$];
        logic [31:0] addr;
        int          pick;
        wait_idle();
        write_reg(CFG_MAX_ATTEMPTS, {24'd0, max_att});
        write_reg(CFG_WINDOW_TICKS, window);
        write_reg(CFG_EXPIRY_TICKS, expiry);
        @(posedge clk);
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        for (int i = 0; i < pool_size; i++)
            pool.push_back($urandom);
        for (int n = 0; n < n_items; n++)
        begin
            if ($urandom_range(99) < jump_pct)
                sim_ticks = sim_ticks + $urandom;
            else
                sim_ticks = sim_ticks + $urandom_range(step_max, 0);
            pick = $urandom_range(99);
            if (pick < hot_pct)
                addr = pool[0];
            else if (pick >= 97)
                addr = $urandom;
            else
                addr = pool[$urandom_range(pool_size - 1, 0)];
            if ($urandom_range(99) < purge_pct)
                queue_item(OP_PURGE, $urandom, sim_ticks);
            else
                queue_item(OP_CONNECT, addr, sim_ticks);
        end
    endtask

    initial
    begin
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] t2;

        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_last[i]  = '0;
            tbl_count[i] = '0;
        end
        send_idle_pct = 6;
        recv_idle_pct = 69;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // A write past the register list must not disturb the reset limits
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        @(posedge clk);

        // Directed part on reset limits (max 5, window 10000, expiry 60000).
        // Start just below the wrap so the window check crosses zero.
        t0 = 32'hFFFF_FF00;
        queue_item(OP_CONNECT, ADDR_LOW, t0);
        for (int k = 1; k <= 5; k++)
            queue_item(OP_CONNECT, ADDR_LOW, t0 + 32'(10 * k));
        // Gap exactly equal to the window keeps counting (and stays limited)
        t1 = t0 + 32'd50 + WINDOW_TICKS_RST;
        queue_item(OP_CONNECT, ADDR_LOW, t1);
        // One tick longer restarts the count
        t2 = t1 + WINDOW_TICKS_RST + 32'd1;
        queue_item(OP_CONNECT, ADDR_LOW, t2);
        queue_item(OP_CONNECT, ADDR_HIGH, t2);
        queue_item(OP_CONNECT, ADDR_MIXED, t2 + 32'd5);
        // Purge exactly at the expiry keeps all, one tick later drops two,
        // then the last one goes; purges carry junk addresses
        queue_item(OP_PURGE, ADDR_HIGH, t2 + EXPIRY_TICKS_RST);
        queue_item(OP_PURGE, ADDR_MIXED, t2 + EXPIRY_TICKS_RST + 32'd1);
        queue_item(OP_PURGE, ADDR_LOW, t2 + EXPIRY_TICKS_RST + 32'd6);
        // A dropped source comes back as a new one in the freed slot
        queue_item(OP_CONNECT, ADDR_LOW, t2 + EXPIRY_TICKS_RST + 32'd6);
        queue_item(OP_CONNECT, ADDR_HIGH, 32'hFFFF_FFFF);
        queue_item(OP_CONNECT, ADDR_MIXED, 32'h0000_0000);
        queue_item(OP_PURGE, ADDR_HIGH, 32'h0000_0000);
        sim_ticks = 32'h0000_0000;

        // max, window, expiry, pool, hot%, step, jump%, purge%, idle in/out, items
        run_phase(8'd4,   32'd500,        32'd4000,       40,  30, 60,  0,   4, 6,  69, 280);
        // All limits at zero: any repeat at a later tick restarts, a repeat
        // at the same tick is limited, a purge drops everything not touched now
        run_phase(8'd0,   32'd0,          32'd0,          100, 20, 2,   0,   3, 6,  69, 280);
        // Limits at their tops: the hot source saturates its count
        run_phase(8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  90,  95, 0,   100, 3, 69, 6,  300);
        // Wide pool with slow time fills the table
        run_phase(8'd7,   32'd3000,       32'd20000,      110, 20, 100, 1,   3, 69, 6,  280);
        run_phase(8'd1,   32'd100,        32'd1000,       24,  40, 40,  2,   5, 0,  0,  260);

        // Drain, then keep watching for stray result items
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
